// ----- rtl/ktbe_pkg.sv -----
// shared types, constants and helper functions of the kalman tilt and bias estimator
package ktbe_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned SAMPLE_BITS_DEF  = 16;
  localparam int unsigned CORDIC_MAX_STEPS = 32;
  localparam int unsigned TAB_IW           = $clog2(CORDIC_MAX_STEPS);
  localparam int unsigned GAIN_FRAC        = 24;
  localparam int unsigned DIV_BITS         = 32 + GAIN_FRAC;

  typedef enum logic [1:0] {
    REG_SAMPLE_PERIOD = 2'd0,
    REG_ANGLE_NOISE   = 2'd1,
    REG_BIAS_NOISE    = 2'd2,
    REG_MEASURE_NOISE = 2'd3
  } cfg_reg_e;

  localparam logic [15:0]        SAMPLE_PERIOD_RST = 16'd1311;
  localparam logic [30:0]        ANGLE_NOISE_RST   = 31'd16777;
  localparam logic [30:0]        BIAS_NOISE_RST    = 31'd50332;
  localparam logic [30:0]        MEASURE_NOISE_RST = 31'd503316;
  localparam logic signed [31:0] COV_ONE           = 32'sd16777216;
  localparam logic signed [33:0] FIX_PI            = 34'sd843314857;
  localparam logic signed [69:0] SAT_MAX           = 70'sd2147483647;
  localparam logic signed [69:0] SAT_MIN           = -70'sd2147483648;

  typedef logic signed [31:0] atan_tab_t [CORDIC_MAX_STEPS];

  // shift-subtract quotient of two non-negative values, only for the table build
  function automatic longint udiv(input longint n, input longint d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in q3.28 from the alternating series taken in q62
  function automatic longint atan_pow2(input int unsigned i);
    longint      sum;
    longint      term;
    longint      sh;
    int unsigned k;
    logic        stop;
    sum  = 0;
    stop = 1'b0;
    if (i == 0) return 64'sd210828714;
    for (k = 0; k < 64; k++) begin
      if (!stop) begin
        sh = 62 - longint'(2 * k + 1) * longint'(i);
        if (sh < 0) begin
          stop = 1'b1;
        end else begin
          term = udiv(longint'(1) <<< sh, longint'(2 * k + 1));
          if (term == 0) stop = 1'b1;
          else if (k[0]) sum = sum - term;
          else sum = sum + term;
        end
      end
    end
    return (sum + (longint'(1) <<< 33)) >>> 34;
  endfunction

  function automatic atan_tab_t build_atan_tab();
    atan_tab_t   t;
    int unsigned i;
    for (i = 0; i < CORDIC_MAX_STEPS; i++) begin
      t[i] = 32'(atan_pow2(i));
    end
    return t;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan_tab();

  // round half up, then floor
  function automatic logic signed [69:0] rnd(input logic signed [69:0] v,
                                             input int unsigned s);
    return (v + (70'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    if (v > SAT_MAX) return 32'sh7fffffff;
    if (v < SAT_MIN) return 32'sh80000000;
    return v[31:0];
  endfunction

  typedef struct packed {
    logic               start;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_z;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [33:0] angle;
  } cordic_rsp_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic [31:0]        den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

endpackage

// ----- rtl/ktbe_if.sv -----
// valid/ready stream interfaces for imu samples and estimates
interface ktbe_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_rate;

  modport source (output valid, accel_x, accel_z, gyro_rate, input ready);
  modport sink   (input valid, accel_x, accel_z, gyro_rate, output ready);
endinterface

interface ktbe_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle_estimate;
  logic signed [31:0] bias_estimate;

  modport source (output valid, angle_estimate, bias_estimate, input ready);
  modport sink   (input valid, angle_estimate, bias_estimate, output ready);
endinterface

// ----- rtl/ktbe_cordic.sv -----
// iterative vectoring cordic giving atan2(accel_x, accel_z) in q3.28
module ktbe_cordic #(
  parameter int unsigned STEPS = ktbe_pkg::CORDIC_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ktbe_pkg::cordic_req_t req_i,
  output ktbe_pkg::cordic_rsp_t rsp_o
);
  import ktbe_pkg::*;

  localparam int unsigned IW = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic                 busy_q;
  logic                 done_q;
  logic [IW-1:0]        cnt_q;
  logic signed [33:0]   x_q, y_q, z_q;
  logic signed [33:0]   xs, ys, tab, x0, y0;

  always_comb begin
    xs  = x_q >>> cnt_q;
    ys  = y_q >>> cnt_q;
    tab = 34'(ATAN_TAB[TAB_IW'(cnt_q)]);
    x0  = 34'(req_i.accel_z) <<< 14;
    y0  = 34'(req_i.accel_x) <<< 14;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
    end else if (req_i.start) begin
      cnt_q <= '0;
      if (req_i.accel_x == 16'sd0 && req_i.accel_z == 16'sd0) begin
        z_q    <= '0;
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        if (req_i.accel_z < 0) begin
          // left half plane: fold over and start from +-pi
          x_q <= -x0;
          y_q <= -y0;
          z_q <= (req_i.accel_x >= 0) ? FIX_PI : -FIX_PI;
        end else begin
          x_q <= x0;
          y_q <= y0;
          z_q <= '0;
        end
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + tab;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - tab;
      end
      if (cnt_q == IW'(STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.angle = z_q;

endmodule

// ----- rtl/ktbe_div.sv -----
// radix-2 restoring divider for the q8.24 gains, one quotient bit per cycle
module ktbe_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ktbe_pkg::div_req_t req_i,
  output ktbe_pkg::div_rsp_t rsp_o
);
  import ktbe_pkg::*;

  localparam int unsigned CW = $clog2(DIV_BITS);

  logic                busy_q;
  logic                done_q;
  logic                neg_q;
  logic [CW-1:0]       cnt_q;
  logic [31:0]         den_q;
  logic [31:0]         rem_q;
  logic [DIV_BITS-1:0] dvd_q;
  logic [32:0]         trial;
  logic                fits;
  logic [31:0]         mag;

  always_comb begin
    trial = {rem_q, dvd_q[DIV_BITS-1]};
    fits  = trial >= {1'b0, den_q};
    mag   = req_i.num[31] ? 32'(-req_i.num) : 32'(req_i.num);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      dvd_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      neg_q  <= req_i.num[31];
      cnt_q  <= '0;
      den_q  <= req_i.den;
      rem_q  <= '0;
      dvd_q  <= {mag, {GAIN_FRAC{1'b0}}};
    end else if (busy_q) begin
      rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
      dvd_q <= {dvd_q[DIV_BITS-2:0], fits};
      if (cnt_q == CW'(DIV_BITS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // quotient magnitude sits in dvd_q once done, sign applied and clamped here
  always_comb begin
    if (!neg_q) begin
      rsp_o.quot = (dvd_q > DIV_BITS'(32'h7fffffff)) ? 32'sh7fffffff
                                                      : dvd_q[31:0];
    end else begin
      rsp_o.quot = (dvd_q > DIV_BITS'(32'h80000000)) ? 32'sh80000000
                                                      : 32'(-dvd_q[31:0]);
    end
    rsp_o.done = done_q;
  end

endmodule

// ----- rtl/kalman_tilt_bias_estimator.sv -----
// Two-state Kalman tilt estimator: each accepted IMU beat (accel_x, accel_z,
// gyro_rate) yields one beat of angle and gyro bias estimates in Q3.28. One
// shared 34x34 multiplier serves the prediction (four products) and the update
// (six products); the CORDIC measurement runs in parallel with the prediction.
// The two gains come from a restoring divider that makes one quotient bit per
// cycle, and where the gains are computed this divider sets the item time; the
// gains are skipped when the innovation covariance is not positive, and a zero
// accelerometer vector skips the CORDIC iterations. A sample is accepted only
// while the block is idle; a finished result waits in an output register and
// holds up nothing until the next result is ready too. Registers are to be
// written through the cfg port only while idle; the block itself does not
// enforce this. sample_period scales dt by 2^-SAMPLE_BITS.
module kalman_tilt_bias_estimator #(
  parameter int unsigned CORDIC_STEPS = ktbe_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned SAMPLE_BITS  = ktbe_pkg::SAMPLE_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [30:0]  cfg_wdata_i,
  ktbe_in_if.sink      in_i,
  ktbe_out_if.source   out_o
);
  import ktbe_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_INNOV, ST_DIV1, ST_DIV2, ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_RATE, OP_CROSS, OP_BB, OP_BB2,
    OP_K1Y, OP_K2Y, OP_K1P11, OP_K1P12, OP_K2P11, OP_K2P12
  } op_e;

  state_e             state_q;
  op_e                op_q;
  logic               mul_ph_q;

  logic [15:0]        sample_period_q;
  logic [30:0]        angle_noise_q, bias_noise_q, measure_noise_q;

  logic signed [31:0] angle_q, bias_q, cov_aa_q, cov_ab_q, cov_ba_q, cov_bb_q;
  logic signed [31:0] ang_q, p11_q, p12_q, p21_q, p22_q;
  logic signed [33:0] t_q, m_q;
  logic signed [31:0] y_q, k1_q, k2_q, div_num_q;
  logic [31:0]        s_q;
  logic signed [15:0] gyro_q, ax_q, az_q;
  logic               cordic_start_q, div_start_q;
  logic signed [67:0] prod_q;

  logic               out_valid_q;
  logic signed [31:0] out_angle_q, out_bias_q;

  logic signed [33:0] mul_a, mul_b, s_sum;
  logic signed [69:0] rdt, rgain;

  cordic_req_t cordic_req;
  cordic_rsp_t cordic_rsp;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  assign cordic_req.start   = cordic_start_q;
  assign cordic_req.accel_x = ax_q;
  assign cordic_req.accel_z = az_q;
  assign div_req.start      = div_start_q;
  assign div_req.num        = div_num_q;
  assign div_req.den        = s_q;

  ktbe_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (cordic_req),
    .rsp_o (cordic_rsp)
  );

  ktbe_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_comb begin
    mul_a = 34'(k1_q);
    mul_b = 34'(y_q);
    case (op_q)
      OP_RATE: begin
        mul_a = 34'($signed({gyro_q, 16'h0000})) - 34'(bias_q);
        mul_b = 34'(sample_period_q);
      end
      OP_CROSS: begin
        mul_a = 34'(cov_ab_q) + 34'(cov_ba_q);
        mul_b = 34'(sample_period_q);
      end
      OP_BB: begin
        mul_a = 34'(cov_bb_q);
        mul_b = 34'(sample_period_q);
      end
      OP_BB2: begin
        mul_a = m_q;
        mul_b = 34'(sample_period_q);
      end
      OP_K1Y:   begin mul_a = 34'(k1_q); mul_b = 34'(y_q);   end
      OP_K2Y:   begin mul_a = 34'(k2_q); mul_b = 34'(y_q);   end
      OP_K1P11: begin mul_a = 34'(k1_q); mul_b = 34'(p11_q); end
      OP_K1P12: begin mul_a = 34'(k1_q); mul_b = 34'(p12_q); end
      OP_K2P11: begin mul_a = 34'(k2_q); mul_b = 34'(p11_q); end
      OP_K2P12: begin mul_a = 34'(k2_q); mul_b = 34'(p12_q); end
      default: ;
    endcase
    rdt   = rnd(70'(prod_q), SAMPLE_BITS);
    rgain = rnd(70'(prod_q), GAIN_FRAC);
    s_sum = 34'(p11_q) + 34'(measure_noise_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      op_q            <= OP_RATE;
      mul_ph_q        <= 1'b0;
      sample_period_q <= SAMPLE_PERIOD_RST;
      angle_noise_q   <= ANGLE_NOISE_RST;
      bias_noise_q    <= BIAS_NOISE_RST;
      measure_noise_q <= MEASURE_NOISE_RST;
      angle_q         <= '0;
      bias_q          <= '0;
      cov_aa_q        <= COV_ONE;
      cov_ab_q        <= '0;
      cov_ba_q        <= '0;
      cov_bb_q        <= COV_ONE;
      cordic_start_q  <= 1'b0;
      div_start_q     <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_SAMPLE_PERIOD: sample_period_q <= cfg_wdata_i[15:0];
          REG_ANGLE_NOISE:   angle_noise_q   <= cfg_wdata_i;
          REG_BIAS_NOISE:    bias_noise_q    <= cfg_wdata_i;
          REG_MEASURE_NOISE: measure_noise_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (out_valid_q && out_o.ready && state_q != ST_OUT) out_valid_q <= 1'b0;
      cordic_start_q <= (state_q == ST_IDLE) && in_i.valid;
      div_start_q    <= (state_q == ST_INNOV && cordic_rsp.done && s_sum > 0) ||
                        (state_q == ST_DIV1 && div_rsp.done && !div_start_q);

      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            gyro_q         <= in_i.gyro_rate;
            ax_q           <= in_i.accel_x;
            az_q           <= in_i.accel_z;
            op_q           <= OP_RATE;
            mul_ph_q       <= 1'b0;
            state_q        <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (!mul_ph_q) begin
            prod_q   <= mul_a * mul_b;
            mul_ph_q <= 1'b1;
          end else begin
            mul_ph_q <= 1'b0;
            case (op_q)
              OP_RATE: begin
                ang_q <= sat32(70'(angle_q) + rdt);
                op_q  <= OP_CROSS;
              end
              OP_CROSS: begin
                t_q  <= rdt[33:0];
                op_q <= OP_BB;
              end
              OP_BB: begin
                m_q   <= rdt[33:0];
                p12_q <= sat32(70'(cov_ab_q) - rdt);
                p21_q <= sat32(70'(cov_ba_q) - rdt);
                p22_q <= sat32(70'(cov_bb_q) + 70'(bias_noise_q));
                op_q  <= OP_BB2;
              end
              OP_BB2: begin
                p11_q   <= sat32(70'(cov_aa_q) - 70'(t_q) + rdt + 70'(angle_noise_q));
                state_q <= ST_INNOV;
              end
              OP_K1Y: begin
                angle_q <= sat32(70'(ang_q) + rgain);
                op_q    <= OP_K2Y;
              end
              OP_K2Y: begin
                bias_q <= sat32(70'(bias_q) + rgain);
                op_q   <= OP_K1P11;
              end
              OP_K1P11: begin
                cov_aa_q <= sat32(70'(p11_q) - rgain);
                op_q     <= OP_K1P12;
              end
              OP_K1P12: begin
                cov_ab_q <= sat32(70'(p12_q) - rgain);
                op_q     <= OP_K2P11;
              end
              OP_K2P11: begin
                cov_ba_q <= sat32(70'(p21_q) - rgain);
                op_q     <= OP_K2P12;
              end
              OP_K2P12: begin
                cov_bb_q <= sat32(70'(p22_q) - rgain);
                state_q  <= ST_OUT;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_INNOV: begin
          if (cordic_rsp.done) begin
            y_q <= sat32(70'(cordic_rsp.angle) - 70'(ang_q));
            if (s_sum <= 0) begin
              // no gain: keep the predicted state
              angle_q  <= ang_q;
              cov_aa_q <= p11_q;
              cov_ab_q <= p12_q;
              cov_ba_q <= p21_q;
              cov_bb_q <= p22_q;
              state_q  <= ST_OUT;
            end else begin
              s_q         <= s_sum[31:0];
              div_num_q   <= p11_q;
              state_q     <= ST_DIV1;
            end
          end
        end
        ST_DIV1: begin
          if (div_rsp.done && !div_start_q) begin
            k1_q        <= div_rsp.quot;
            div_num_q   <= p21_q;
            state_q     <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (div_rsp.done && !div_start_q) begin
            k2_q     <= div_rsp.quot;
            op_q     <= OP_K1Y;
            mul_ph_q <= 1'b0;
            state_q  <= ST_MUL;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_angle_q <= angle_q;
            out_bias_q  <= bias_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready           = (state_q == ST_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.angle_estimate = out_angle_q;
  assign out_o.bias_estimate  = out_bias_q;

endmodule

// ----- rtl/ktbe_chk.sv -----
// port-level checks of the estimator, bound to the top level
module ktbe_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_angle,
  input logic [31:0] out_bias
);

  // one sample at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a sample is in flight");

  // a new result only appears at the end of a sample's work
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result beat without sample in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_angle) && $stable(out_bias))
    else $error("stalled result beat changed");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid)
    else $error("result valid during reset");

endmodule

bind kalman_tilt_bias_estimator ktbe_chk u_ktbe_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_valid (in_i.valid),
  .in_ready (in_i.ready),
  .out_valid(out_o.valid),
  .out_ready(out_o.ready),
  .out_angle(out_o.angle_estimate),
  .out_bias (out_o.bias_estimate)
);
